// ===== sv/sew_pkg.sv =====
// Package for the stall escalation watchdog: widths, level and register codes,
// and the reciprocal constant used for the microseconds-to-seconds scaling.
// No dependencies.
`default_nettype none

package sew_pkg;

    localparam int TIME_BITS   = 48;
    localparam int HEIGHT_BITS = 48;
    localparam int SECS_W      = 20;
    localparam int AGE_W       = 29;
    localparam int COUNT_W     = 32;
    localparam int LEVEL_W     = 2;
    localparam int CFG_IDX_W   = 4;

    // One second in microseconds, split into a power of two and an odd factor
    localparam int US_PER_SEC  = 1000000;
    localparam int POW2_SHIFT  = 6;
    localparam int DIV_ODD     = US_PER_SEC >> POW2_SHIFT;
    localparam int RECIP_L     = $clog2(DIV_ODD);

    // Threshold compare is done in microseconds
    localparam int THR_W       = SECS_W + $clog2(US_PER_SEC);

    // Reciprocal multiply: q = (x * RECIP) >> QSH, exact for every x below 2**XW
    localparam int XW          = TIME_BITS - POW2_SHIFT;
    localparam int MW          = XW + 1;
    localparam int QSH         = XW + RECIP_L;
    localparam int SUM_W       = XW + MW;
    localparam int XL          = XW / 2;
    localparam int XH          = XW - XL;
    localparam int ML          = MW / 2;
    localparam int MH          = MW - ML;

    localparam logic [127:0] RECIP_WIDE =
        ((128'(1) << QSH) + 128'(DIV_ODD) - 128'(1)) / 128'(DIV_ODD);
    localparam logic [MW-1:0] RECIP = RECIP_WIDE[MW-1:0];

    // Reset thresholds in seconds
    localparam logic [SECS_W-1:0] FIRST_RESET   = SECS_W'(300);
    localparam logic [SECS_W-1:0] RESTART_RESET = SECS_W'(1200);

    // Escalation levels
    localparam logic [LEVEL_W-1:0] LVL_NONE  = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_FIRST = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_SHUT  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_STAGE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_STAGE = CFG_IDX_W'(1);

endpackage

`default_nettype wire

// ===== sv/stall_escalation_watchdog.sv =====
// Items pass capture, partial-product and quotient registers to the m_ channel.
// Throughput: one item per cycle unless m_ready stalls; the state update is done
// on acceptance and the seconds age runs through a two-stage reciprocal multiplier.
// Reset (aresetn low, synchronous): state, counters and pipeline valids clear,
// thresholds return to 300 s and 1200 s. No clearing pass is needed.
// Uses sew_pkg for widths, codes and the reciprocal constant.
`default_nettype none

module stall_escalation_watchdog (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sew_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sew_pkg::SECS_W-1:0]        cfg_data,
    // tick channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [sew_pkg::HEIGHT_BITS-1:0]   s_progress_height,
    input  wire logic [sew_pkg::TIME_BITS-1:0]     s_time_us,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_advanced,
    output logic                                   m_fire_first_stage,
    output logic                                   m_fire_shutdown,
    output logic [sew_pkg::LEVEL_W-1:0]            m_level_now,
    output logic [sew_pkg::AGE_W-1:0]              m_stall_age_secs,
    output logic [sew_pkg::HEIGHT_BITS-1:0]        m_highest_height,
    output logic [sew_pkg::COUNT_W-1:0]            m_first_stage_count,
    output logic [sew_pkg::COUNT_W-1:0]            m_shutdown_count
);

    typedef struct packed {
        logic                              advanced;
        logic                              fire_first;
        logic                              fire_shut;
        logic [sew_pkg::LEVEL_W-1:0]       level;
        logic [sew_pkg::HEIGHT_BITS-1:0]   highest;
        logic [sew_pkg::COUNT_W-1:0]       first_count;
        logic [sew_pkg::COUNT_W-1:0]       shut_count;
    } result_t;

    // Thresholds, held pre-scaled to microseconds
    logic [sew_pkg::THR_W-1:0]       thr_first_reg;
    logic [sew_pkg::THR_W-1:0]       thr_shut_reg;

    // Watchdog state
    logic [sew_pkg::HEIGHT_BITS-1:0] best_reg,    best_next;
    logic [sew_pkg::TIME_BITS-1:0]   adv_time_reg, adv_time_next;
    logic                            started_reg, started_next;
    logic [sew_pkg::LEVEL_W-1:0]     level_reg,   level_next;
    logic [sew_pkg::COUNT_W-1:0]     first_cnt_reg, first_cnt_next;
    logic [sew_pkg::COUNT_W-1:0]     shut_cnt_reg,  shut_cnt_next;

    // Pipeline stages
    logic                            v1_reg, v2_reg, v3_reg;
    result_t                         res1_reg, res2_reg, res3_reg;
    result_t                         res1_next;
    logic [sew_pkg::XW-1:0]          x1_reg, x1_next;
    logic [sew_pkg::XH+sew_pkg::MH-1:0] pp_hh_reg;
    logic [sew_pkg::XH+sew_pkg::ML-1:0] pp_hl_reg;
    logic [sew_pkg::XL+sew_pkg::MH-1:0] pp_lh_reg;
    logic [sew_pkg::XL+sew_pkg::ML-1:0] pp_ll_reg;
    logic [sew_pkg::AGE_W-1:0]       age3_reg;

    logic                            rdy1, rdy2, rdy3;
    logic                            in_fire;
    logic [sew_pkg::SUM_W-1:0]       prod_sum;

    // Stage readiness chained back from the result channel
    assign rdy3      = !v3_reg || m_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign s_ready   = rdy1;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;

    // Step the watchdog state for the incoming item
    always_comb begin
        logic                          adv;
        logic                          time_ok;
        logic [sew_pkg::TIME_BITS-1:0] diff;
        logic                          hit_first;
        logic                          hit_shut;
        adv       = s_progress_height > best_reg;
        time_ok   = s_time_us >= adv_time_reg;
        diff      = s_time_us - adv_time_reg;
        hit_first = 1'b0;
        hit_shut  = 1'b0;

        best_next      = best_reg;
        adv_time_next  = adv_time_reg;
        started_next   = started_reg;
        level_next     = level_reg;
        first_cnt_next = first_cnt_reg;
        shut_cnt_next  = shut_cnt_reg;
        x1_next        = '0;

        if (adv) begin
            best_next     = s_progress_height;
            adv_time_next = s_time_us;
            started_next  = 1'b1;
            level_next    = sew_pkg::LVL_NONE;
        end else if (!started_reg) begin
            adv_time_next = s_time_us;
            started_next  = 1'b1;
        end else begin
            // age >= T seconds exactly when diff >= T * 1e6
            hit_first = time_ok && (level_reg == sew_pkg::LVL_NONE) &&
                        (diff >= sew_pkg::TIME_BITS'(thr_first_reg));
            hit_shut  = time_ok && (level_reg != sew_pkg::LVL_SHUT) &&
                        (diff >= sew_pkg::TIME_BITS'(thr_shut_reg));
            if (time_ok) begin
                x1_next = diff[sew_pkg::TIME_BITS-1:sew_pkg::POW2_SHIFT];
            end
            if (hit_first) begin
                level_next = sew_pkg::LVL_FIRST;
                if (first_cnt_reg != '1) begin
                    first_cnt_next = first_cnt_reg + 1'b1;
                end
            end
            if (hit_shut) begin
                level_next = sew_pkg::LVL_SHUT;
                if (shut_cnt_reg != '1) begin
                    shut_cnt_next = shut_cnt_reg + 1'b1;
                end
            end
        end

        res1_next.advanced    = adv;
        res1_next.fire_first  = hit_first;
        res1_next.fire_shut   = hit_shut;
        res1_next.level       = level_next;
        res1_next.highest     = best_next;
        res1_next.first_count = first_cnt_next;
        res1_next.shut_count  = shut_cnt_next;
    end

    // Combine partial products and take the quotient bits
    assign prod_sum =
        (sew_pkg::SUM_W'(pp_hh_reg) << (sew_pkg::XL + sew_pkg::ML)) +
        (sew_pkg::SUM_W'(pp_hl_reg) << sew_pkg::XL) +
        (sew_pkg::SUM_W'(pp_lh_reg) << sew_pkg::ML) +
        sew_pkg::SUM_W'(pp_ll_reg);

    // Configuration registers; a zero or unknown-index write is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_first_reg <= sew_pkg::THR_W'(sew_pkg::FIRST_RESET) *
                             sew_pkg::THR_W'(sew_pkg::US_PER_SEC);
            thr_shut_reg  <= sew_pkg::THR_W'(sew_pkg::RESTART_RESET) *
                             sew_pkg::THR_W'(sew_pkg::US_PER_SEC);
        end else if (cfg_valid && cfg_ready && (cfg_data != '0)) begin
            case (cfg_index)
                sew_pkg::CFG_FIRST_STAGE: begin
                    thr_first_reg <= sew_pkg::THR_W'(cfg_data) *
                                     sew_pkg::THR_W'(sew_pkg::US_PER_SEC);
                end
                sew_pkg::CFG_RESTART_STAGE: begin
                    thr_shut_reg <= sew_pkg::THR_W'(cfg_data) *
                                    sew_pkg::THR_W'(sew_pkg::US_PER_SEC);
                end
                default: begin
                end
            endcase
        end
    end

    // Watchdog state and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= '0;
            adv_time_reg  <= '0;
            started_reg   <= 1'b0;
            level_reg     <= sew_pkg::LVL_NONE;
            first_cnt_reg <= '0;
            shut_cnt_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end else begin
            if (in_fire) begin
                best_reg      <= best_next;
                adv_time_reg  <= adv_time_next;
                started_reg   <= started_next;
                level_reg     <= level_next;
                first_cnt_reg <= first_cnt_next;
                shut_cnt_reg  <= shut_cnt_next;
            end
            if (rdy1) begin
                v1_reg <= in_fire;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Pipeline payload: capture, partial products, quotient
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res1_reg <= res1_next;
            x1_reg   <= x1_next;
        end
        if (rdy2 && v1_reg) begin
            res2_reg  <= res1_reg;
            pp_hh_reg <= x1_reg[sew_pkg::XW-1:sew_pkg::XL] *
                         sew_pkg::RECIP[sew_pkg::MW-1:sew_pkg::ML];
            pp_hl_reg <= x1_reg[sew_pkg::XW-1:sew_pkg::XL] *
                         sew_pkg::RECIP[sew_pkg::ML-1:0];
            pp_lh_reg <= x1_reg[sew_pkg::XL-1:0] *
                         sew_pkg::RECIP[sew_pkg::MW-1:sew_pkg::ML];
            pp_ll_reg <= x1_reg[sew_pkg::XL-1:0] *
                         sew_pkg::RECIP[sew_pkg::ML-1:0];
        end
        if (rdy3 && v2_reg) begin
            res3_reg <= res2_reg;
            age3_reg <= prod_sum[sew_pkg::QSH +: sew_pkg::AGE_W];
        end
    end

    // Drive the result channel
    assign m_valid             = v3_reg;
    assign m_advanced          = res3_reg.advanced;
    assign m_fire_first_stage  = res3_reg.fire_first;
    assign m_fire_shutdown     = res3_reg.fire_shut;
    assign m_level_now         = res3_reg.level;
    assign m_stall_age_secs    = age3_reg;
    assign m_highest_height    = res3_reg.highest;
    assign m_first_stage_count = res3_reg.first_count;
    assign m_shutdown_count    = res3_reg.shut_count;

endmodule

`default_nettype wire

// ===== dv/stall_escalation_watchdog_tb.sv =====
// Self-checking testbench for stall_escalation_watchdog: drives tick items through a
// bursty sender, predicts every result from its own model of the escalation logic and
// checks each result item field by field. Depends on sew_pkg and the block's RTL.

module stall_escalation_watchdog_tb;

    import sew_pkg::*;

    localparam logic [63:0] ONE_SEC_US = 64'd1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 20000;

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = '1;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] height;
        logic [TIME_BITS-1:0]   stamp;
    } tick_t;

    typedef struct packed {
        logic                   advanced;
        logic                   fire_first;
        logic                   fire_shut;
        logic [LEVEL_W-1:0]     level;
        logic [AGE_W-1:0]       age;
        logic [HEIGHT_BITS-1:0] highest;
        logic [COUNT_W-1:0]     first_count;
        logic [COUNT_W-1:0]     shut_count;
    } watch_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [SECS_W-1:0]      cfg_data  = '0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [HEIGHT_BITS-1:0] s_progress_height = '0;
    logic [TIME_BITS-1:0]   s_time_us = '0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_advanced;
    logic                   m_fire_first_stage;
    logic                   m_fire_shutdown;
    logic [LEVEL_W-1:0]     m_level_now;
    logic [AGE_W-1:0]       m_stall_age_secs;
    logic [HEIGHT_BITS-1:0] m_highest_height;
    logic [COUNT_W-1:0]     m_first_stage_count;
    logic [COUNT_W-1:0]     m_shutdown_count;

    stall_escalation_watchdog u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_progress_height   (s_progress_height),
        .s_time_us           (s_time_us),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_advanced          (m_advanced),
        .m_fire_first_stage  (m_fire_first_stage),
        .m_fire_shutdown     (m_fire_shutdown),
        .m_level_now         (m_level_now),
        .m_stall_age_secs    (m_stall_age_secs),
        .m_highest_height    (m_highest_height),
        .m_first_stage_count (m_first_stage_count),
        .m_shutdown_count    (m_shutdown_count)
    );

    always #1 aclk = ~aclk;

    tick_t         pending_ticks[$];
    watch_result_t results_due[$];
    int            mismatches   = 0;
    int            results_seen = 0;

    // Escalation model state and its copy of the thresholds
    logic [HEIGHT_BITS-1:0] w_best;
    logic [TIME_BITS-1:0]   w_since;
    logic                   w_armed;
    logic [LEVEL_W-1:0]     w_level;
    logic [COUNT_W-1:0]     w_first_n;
    logic [COUNT_W-1:0]     w_shut_n;
    logic [SECS_W-1:0]      thr_first;
    logic [SECS_W-1:0]      thr_shutdown;

    function automatic watch_result_t predict_tick(input logic [HEIGHT_BITS-1:0] height,
                                                   input logic [TIME_BITS-1:0] now);
        watch_result_t r;
        logic [LEVEL_W-1:0]   held;
        logic [TIME_BITS-1:0] age;
        r = '0;
        if (height > w_best) begin
            // new high mark: restart the stall clock and drop the level
            w_best  = height;
            w_since = now;
            w_armed = 1'b1;
            w_level = LVL_NONE;
            r.advanced = 1'b1;
        end else if (!w_armed) begin
            w_since = now;
            w_armed = 1'b1;
        end else begin
            // both tests use the level held before this tick
            held = w_level;
            age  = (now >= w_since) ? TIME_BITS'((now - w_since) / ONE_SEC_US) : '0;
            if (held < LVL_FIRST && age >= TIME_BITS'(thr_first)) begin
                w_level = LVL_FIRST;
                if (w_first_n != '1) w_first_n = w_first_n + 1'b1;
                r.fire_first = 1'b1;
            end
            if (held < LVL_SHUT && age >= TIME_BITS'(thr_shutdown)) begin
                w_level = LVL_SHUT;
                if (w_shut_n != '1) w_shut_n = w_shut_n + 1'b1;
                r.fire_shut = 1'b1;
            end
            r.age = age[AGE_W-1:0];
        end
        r.level       = w_level;
        r.highest     = w_best;
        r.first_count = w_first_n;
        r.shut_count  = w_shut_n;
        return r;
    endfunction

    // Sender: offer queued items in bursts separated by random gaps
    int    gap_left      = 0;
    int    burst_left    = 0;
    logic  sender_steady = 1'b0;
    tick_t offer;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                results_due.push_back(predict_tick(s_progress_height, s_time_us));
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    offer = pending_ticks.pop_front();
                    s_valid           <= 1'b1;
                    s_progress_height <= offer.height;
                    s_time_us         <= offer.stamp;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        if (sender_steady || $urandom_range(0, 2) == 0) begin
                            gap_left <= 0;
                        end else begin
                            gap_left <= $urandom_range(1, 12);
                        end
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall in segments of random density, or hold off on request
    logic hold_start = 1'b0;
    int   hold_left  = 0;
    int   seg_left   = 0;
    int   ready_pct  = 100;

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(1, 64);
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 75;
                    2: ready_pct <= 40;
                    default: ready_pct <= 10;
                endcase
            end else begin
                seg_left <= seg_left - 1;
            end
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH result %0d %s: expected %0d, got %0d",
                         results_seen, field, want, got);
            end
        end
    endtask

    // Monitor: compare each accepted result item with the oldest expectation
    watch_result_t due_now;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH result %0d arrived with nothing expected", results_seen);
                end
            end else begin
                due_now = results_due.pop_front();
                check_field("advanced", due_now.advanced, m_advanced);
                check_field("fire_first_stage", due_now.fire_first, m_fire_first_stage);
                check_field("fire_shutdown", due_now.fire_shut, m_fire_shutdown);
                check_field("level_now", due_now.level, m_level_now);
                check_field("stall_age_secs", due_now.age, m_stall_age_secs);
                check_field("highest_height", due_now.highest, m_highest_height);
                check_field("first_stage_count", due_now.first_count, m_first_stage_count);
                check_field("shutdown_count", due_now.shut_count, m_shutdown_count);
            end
            results_seen++;
        end
    end

    // Watchdog: end the run when no channel moves for too long
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus generation state
    logic [HEIGHT_BITS-1:0] gen_best = '0;
    logic [TIME_BITS-1:0]   gen_now  = '0;
    logic [TIME_BITS-1:0]   gen_mark = '0;
    int                     items_made = 0;

    function automatic logic [TIME_BITS-1:0] secs(input longint unsigned n);
        return TIME_BITS'(64'(n) * ONE_SEC_US);
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [HEIGHT_BITS-1:0] rand_upto(input logic [HEIGHT_BITS-1:0] lim);
        if (lim == '1) return rand48();
        return HEIGHT_BITS'(64'(rand48()) % (64'(lim) + 64'd1));
    endfunction

    task automatic add_tick(input logic [HEIGHT_BITS-1:0] height,
                            input logic [TIME_BITS-1:0] stamp);
        tick_t t;
        t.height = height;
        t.stamp  = stamp;
        pending_ticks.push_back(t);
        if (height > gen_best) begin
            gen_best = height;
            gen_mark = stamp;
        end
        items_made++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_ticks.size() != 0 || s_valid || results_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SECS_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // zero writes and unknown indexes leave the thresholds alone
        if (data != '0) begin
            if (idx == CFG_FIRST_STAGE) thr_first = data;
            else if (idx == CFG_RESTART_STAGE) thr_shutdown = data;
        end
    endtask

    task automatic set_thresholds(input logic [SECS_W-1:0] first, input logic [SECS_W-1:0] restart);
        wait_drained();
        write_reg(CFG_FIRST_STAGE, first);
        write_reg(CFG_RESTART_STAGE, restart);
        @(negedge aclk);
    endtask

    // Mostly advance-then-stall runs with random timing, plus stray ticks
    task automatic make_random(input int count, input int unsigned step_us);
        int stop;
        int runs;
        int k;
        stop = items_made + count;
        while (items_made < stop) begin
            if ($urandom_range(0, 9) < 8) begin
                gen_now = gen_now + $urandom_range(0, 1000000);
                if (gen_now > 48'h4000_0000_0000) gen_now = $urandom_range(0, 1000);
                add_tick(gen_best + $urandom_range(1, 4096), gen_now);
                runs = $urandom_range(1, 8);
                for (k = 0; k < runs; k++) begin
                    case ($urandom_range(0, 9))
                        0: gen_now = gen_mark + secs(thr_first) - $urandom_range(0, 1);
                        1: gen_now = gen_mark + secs(thr_shutdown) - $urandom_range(0, 1);
                        2: gen_now = gen_mark - $urandom_range(1, 1000000);
                        default: gen_now = gen_now + $urandom_range(0, step_us);
                    endcase
                    add_tick(rand_upto(gen_best), gen_now);
                end
            end else begin
                add_tick(rand_upto(gen_best), rand48());
            end
        end
    endtask

    initial begin
        logic [TIME_BITS-1:0] t0;

        w_best       = '0;
        w_since      = '0;
        w_armed      = 1'b0;
        w_level      = LVL_NONE;
        w_first_n    = '0;
        w_shut_n     = '0;
        thr_first    = FIRST_RESET;
        thr_shutdown = RESTART_RESET;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset thresholds: first tick arms the timer, then walk both boundaries
        add_tick('0, '0);
        add_tick('0, secs(300) - 1);
        add_tick('0, secs(300));
        add_tick('0, secs(1200) - 1);
        add_tick('0, secs(1200));
        add_tick('0, '1);
        add_tick(48'd1, secs(10));
        add_tick(48'd1, secs(5));
        add_tick('0, secs(1510));
        add_tick(48'd2, secs(2000));
        gen_now = secs(2000);
        make_random(60, 500000000);

        // Zero data and unknown indexes must not disturb the thresholds
        wait_drained();
        write_reg(CFG_FIRST_STAGE, '0);
        write_reg(CFG_RESTART_STAGE, '0);
        write_reg(CFG_IDX_SPARE, SECS_W'(7));
        write_reg(CFG_IDX_TOP, SECS_W'(9));
        @(negedge aclk);
        t0 = gen_now + secs(1);
        add_tick(gen_best + 1'b1, t0);
        add_tick(gen_best, t0 + secs(300) - 1);
        add_tick(gen_best, t0 + secs(300));
        add_tick(gen_best, t0 + secs(1200));

        // Smallest first stage, largest restart stage
        set_thresholds(SECS_W'(1), '1);
        t0 = t0 + secs(2000);
        add_tick(gen_best + 1'b1, t0);
        add_tick(gen_best, t0 + secs(1) - 1'b1);
        add_tick(gen_best, t0 + secs(1));
        add_tick(gen_best, t0 + secs(1048575) - 1);
        add_tick(gen_best, t0 + secs(1048575));

        // Restart stage below first stage: shutdown alone, then both at once
        set_thresholds('1, SECS_W'(1));
        t0 = t0 + secs(1048576);
        add_tick(gen_best + 1'b1, t0);
        add_tick(gen_best, t0 + secs(1));
        add_tick(gen_best, t0 + secs(1048575));
        t0 = t0 + secs(1048576);
        add_tick(gen_best + 1'b1, t0);
        add_tick(gen_best, t0 + secs(1048575));
        gen_now = t0 + secs(1048575);

        set_thresholds(SECS_W'(2), SECS_W'(5));
        make_random(200, 2000000);

        // Hold the result side off while the sender keeps pushing
        set_thresholds(SECS_W'(4), SECS_W'(4));
        sender_steady = 1'b1;
        @(posedge aclk);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        @(negedge aclk);
        make_random(150, 1500000);
        wait_drained();
        sender_steady = 1'b0;

        set_thresholds(SECS_W'(6), SECS_W'(3));
        make_random(200, 2500000);
        set_thresholds(SECS_W'(1), SECS_W'(1));
        make_random(200, 600000);
        repeat (2) begin
            set_thresholds(SECS_W'($urandom_range(1, 8)), SECS_W'($urandom_range(1, 8)));
            make_random(200, 3000000);
        end

        // Top height: no further advance, heights and times over their full range
        set_thresholds(SECS_W'($urandom_range(1, 1000)), SECS_W'($urandom_range(1, 1000)));
        add_tick('1, rand48());
        repeat (100) add_tick(rand48(), rand48());
        add_tick('1, rand48());

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
